@@ rtl/dsss_pkg.sv @@
// Package with shared types and constants of the section save scheduler.
`timescale 1ns / 1ps
package dsss_pkg;
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_SAVE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_ADD_FAIL  = 3'd1;
  localparam logic [2:0] ST_ARMED     = 3'd2;
  localparam logic [2:0] ST_SAVE_FAIL = 3'd3;
  localparam logic [2:0] ST_WRITE     = 3'd4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_TOTAL = 2'd1;
  localparam logic [1:0] REG_GRAIN = 2'd2;
  localparam logic [1:0] REG_PAUSE = 2'd3;

  localparam logic [16:0] HDR_BYTES = 17'd3;

  typedef enum logic [1:0] {
    S_IDLE, S_ALIGN, S_SCAN, S_DRAIN
  } state_t;

  // One table entry as it moves along the ring of cells.
  typedef struct packed {
    logic        armed;
    logic [31:0] countdown;
    logic [31:0] address;
    logic [15:0] size;
  } entry_t;
endpackage

@@ rtl/deferred_section_save_scheduler.sv @@
// Top level of the deferred section save scheduler.
// Usage: input transactions arrive on the s_axis channel (tdata holds action,
// section_id, data_size and delay_ticks), results leave on m_axis with tlast marking
// the final result of a transaction. Registers are written over the cfg channel,
// which is ready only while the block is idle.
// The section table is a ring of MAX_SECTIONS cells; every transaction rotates it
// once fully, one cell a cycle, and the entry at the tail is updated on its way
// back to the first cell. Entry i rests in cell MAX_SECTIONS-1-i.
// A save, tick or ignored transaction rotates the ring and then passes its last
// result on from the holding register before the next accept.
// An add first finds the remainder of its end offset by the grain, one bit a
// cycle over all 33 bits, checks that the section fits, and then rotates the ring.
// Transactions are taken one at a time.
// Each result waits in a one-deep holding register until the next one is found or
// the rotation ends. While the output register is full and not taken, the ring halts.
// Reset clears the section count, the offset, all armed flags and countdowns,
// and the registers to their defaults. There is no clearing pass.
`timescale 1ns / 1ps
module deferred_section_save_scheduler #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // action[1:0], section_id[9:2],
                                     // data_size[25:10], delay_ticks[57:26]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // status[2:0], result_id[10:3],
                                     // write_address[42:11], write_length[59:43]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dsss_pkg::*;

  localparam int IW = $clog2(MAX_SECTIONS + 1);

  logic [31:0] medium_base, medium_size;
  logic [7:0]  erase_grain;
  logic        paused;

  logic [IW-1:0] section_count;
  logic [31:0]   next_offset;

  state_t state, state_next;

  logic [1:0]    act;
  logic [7:0]    id;
  logic [15:0]   dsize;
  logic [31:0]   delay;
  logic [IW-1:0] pos;          // number of cells rotated so far
  logic [32:0]   end_in;       // unaligned end of a new section, at accept
  logic [32:0]   end_raw;
  logic [32:0]   div_sh;       // end offset shifted out MSB first
  logic [5:0]    div_cnt;
  logic [8:0]    rem;
  logic [8:0]    div_t;
  logic [8:0]    rem_step;
  logic [7:0]    gr;
  logic [8:0]    pad;
  logic [32:0]   end_al;
  logic          add_ok;

  logic          pend_valid;
  logic [2:0]    pend_status;
  logic [7:0]    pend_id;
  logic [31:0]   pend_addr;
  logic [16:0]   pend_len;

  logic          o_valid;
  logic [2:0]    o_status;
  logic [7:0]    o_id;
  logic [31:0]   o_addr;
  logic [16:0]   o_len;
  logic          o_last;

  entry_t        cells [MAX_SECTIONS];
  entry_t        tail;
  entry_t        head;
  logic          rotating;
  logic          out_free;
  logic          in_table;
  logic          tick_on;
  logic          expire;
  logic          bad_id;
  logic          id_match;
  logic [31:0]   cd_dec;
  logic [IW-1:0] last_pos;

  logic          hit;
  logic [2:0]    hit_status;
  logic [7:0]    hit_id;
  logic [31:0]   hit_addr;
  logic [16:0]   hit_len;
  logic          pend_load;
  logic          pend_clr;
  logic          o_load;

  assign tail = cells[MAX_SECTIONS-1];

  genvar g;
  generate
    for (g = 0; g < MAX_SECTIONS; g++) begin : g_cell
      if (g == 0) begin : g_first
        dsss_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (rotating),
          .d     (head),
          .q     (cells[g])
        );
      end else begin : g_rest
        dsss_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (rotating),
          .d     (cells[g-1]),
          .q     (cells[g])
        );
      end
    end
  endgenerate

  assign last_pos = IW'(MAX_SECTIONS - 1);
  assign out_free = !o_valid || m_axis_tready;
  assign in_table = (pos < section_count);
  assign tick_on  = (act == ACT_TICK) && !paused;
  assign cd_dec   = tail.countdown - 32'd1;
  assign expire   = tick_on && in_table && tail.armed && (tail.countdown == 32'd1);
  assign bad_id   = (id == 8'd0) || (9'(id) > 9'(section_count));
  assign id_match = (9'(id) == 9'(pos) + 9'd1);

  // Remainder of the end offset by the grain, one bit a cycle.
  assign gr       = (erase_grain == 8'd0) ? 8'd1 : erase_grain;
  assign div_t    = {rem[7:0], div_sh[32]};
  assign rem_step = (div_t >= {1'b0, gr}) ? (div_t - {1'b0, gr}) : div_t;
  assign pad      = (rem == 9'd0) ? 9'd0 : ({1'b0, gr} - rem);
  assign end_al   = end_raw + 33'(pad);
  assign end_in   = 33'(next_offset) + 33'(s_axis_tdata[25:10]) + 33'(HDR_BYTES);

  always_comb begin
    head = tail;
    if (in_table) begin
      if ((act == ACT_SAVE) && !bad_id && id_match && (delay != 32'd0)) begin
        head.armed = 1'b1;
        if (tail.countdown < delay) head.countdown = delay;
      end else if (tick_on && tail.armed && (tail.countdown != 32'd0)) begin
        head.countdown = cd_dec;
        if (cd_dec == 32'd0) head.armed = 1'b0;
      end
    end else if ((act == ACT_ADD) && add_ok && (pos == section_count)) begin
      head.armed     = 1'b0;
      head.countdown = '0;
      head.address   = medium_base + next_offset;
      head.size      = dsize;
    end
  end

  // Result found at the current ring position, if any.
  always_comb begin
    hit        = 1'b0;
    hit_status = ST_ADDED;
    hit_id     = '0;
    hit_addr   = '0;
    hit_len    = '0;
    case (act)
      ACT_ADD: begin
        hit = (pos == '0);
        if (add_ok) begin
          hit_status = ST_ADDED;
          hit_id     = 8'(section_count) + 8'd1;
          hit_addr   = medium_base + next_offset;
          hit_len    = 17'(dsize) + HDR_BYTES;
        end else begin
          hit_status = ST_ADD_FAIL;
        end
      end
      ACT_SAVE: begin
        if (bad_id) begin
          hit        = (pos == '0);
          hit_status = ST_SAVE_FAIL;
        end else begin
          hit        = id_match;
          hit_status = (delay == 32'd0) ? ST_WRITE : ST_ARMED;
          hit_id     = id;
          hit_addr   = tail.address;
          hit_len    = 17'(tail.size) + HDR_BYTES;
        end
      end
      ACT_TICK: begin
        hit        = expire;
        hit_status = ST_WRITE;
        hit_id     = 8'(pos) + 8'd1;
        hit_addr   = tail.address;
        hit_len    = 17'(tail.size) + HDR_BYTES;
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_next = (s_axis_tdata[1:0] == ACT_ADD) ? S_ALIGN : S_SCAN;
        end
      end
      S_ALIGN: if (div_cnt == 6'd0) state_next = S_SCAN;
      S_SCAN:  if (rotating && (pos == last_pos)) state_next = S_DRAIN;
      S_DRAIN: if (!pend_valid || out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    cfg_ready     = (state == S_IDLE);
    rotating      = (state == S_SCAN) && out_free;
    pend_load     = rotating && hit;
    pend_clr      = (state == S_DRAIN) && pend_valid && out_free;
    o_load        = (pend_load && pend_valid) || pend_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      medium_base   <= '0;
      medium_size   <= '0;
      erase_grain   <= 8'd1;
      paused        <= 1'b0;
      section_count <= '0;
      next_offset   <= '0;
      o_valid       <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE:  medium_base <= cfg_data;
          REG_TOTAL: medium_size <= cfg_data;
          REG_GRAIN: erase_grain <= cfg_data[7:0];
          REG_PAUSE: paused      <= cfg_data[0];
          default:   ;
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
      if (rotating && (pos == last_pos) && (act == ACT_ADD) && add_ok) begin
        section_count <= section_count + IW'(1);
        next_offset   <= end_al[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act     <= s_axis_tdata[1:0];
      id      <= s_axis_tdata[9:2];
      dsize   <= s_axis_tdata[25:10];
      delay   <= s_axis_tdata[57:26];
      end_raw <= end_in;
      div_sh  <= end_in;
      div_cnt <= 6'd33;
      rem     <= '0;
      pos     <= '0;
    end else if (state == S_ALIGN) begin
      if (div_cnt != 6'd0) begin
        div_sh  <= {div_sh[31:0], 1'b0};
        rem     <= rem_step;
        div_cnt <= div_cnt - 6'd1;
      end else begin
        add_ok <= (section_count < IW'(MAX_SECTIONS)) && (end_al <= 33'(medium_size));
      end
    end else if (rotating) begin
      pos <= pos + IW'(1);
    end
    if (pend_load) begin
      pend_status <= hit_status;
      pend_id     <= hit_id;
      pend_addr   <= hit_addr;
      pend_len    <= hit_len;
    end
    if (o_load) begin
      o_status <= pend_status;
      o_id     <= pend_id;
      o_addr   <= pend_addr;
      o_len    <= pend_len;
      o_last   <= (state == S_DRAIN);
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {4'd0, o_len, o_addr, o_id, o_status};
endmodule

@@ rtl/dsss_cell.sv @@
// One storage cell of the section table ring.
`timescale 1ns / 1ps
module dsss_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  dsss_pkg::entry_t d,
  output dsss_pkg::entry_t q
);
  always_ff @(posedge clk) begin
    if (rst) begin
      q.armed     <= 1'b0;
      q.countdown <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

@@ tb/sv/save_scheduler_checker.sv @@
// Checker that predicts and compares the results of the section save scheduler.
`timescale 1ns / 1ps
module save_scheduler_checker #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  import dsss_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  id;
    logic [31:0] address;
    logic [16:0] length;
    logic        last;
  } save_result_t;

  save_result_t result_queue[$];

  logic [31:0] base_q, total_q;
  logic [7:0]  grain_q;
  logic        paused_q;
  int unsigned count_q;
  logic [31:0] offset_q;
  logic [31:0] addr_q[MAX_SECTIONS];
  logic [15:0] size_q[MAX_SECTIONS];
  logic        armed_q[MAX_SECTIONS];
  logic [31:0] countdown_q[MAX_SECTIONS];

  function automatic save_result_t make_result(logic [2:0] st, logic [7:0] id,
                                               logic [31:0] a, logic [16:0] l);
    save_result_t r;
    r.status = st;
    r.id = id;
    r.address = a;
    r.length = l;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_item(logic [63:0] d);
    logic [1:0]  act;
    logic [7:0]  id;
    logic [15:0] sz;
    logic [31:0] dly;
    logic [63:0] g, fin;
    save_result_t batch[$];
    act = d[1:0];
    id = d[9:2];
    sz = d[25:10];
    dly = d[57:26];
    if (act == ACT_ADD) begin
      g = (grain_q == 0) ? 64'd1 : 64'(grain_q);
      fin = 64'(offset_q) + 64'(sz) + 64'd3;
      fin = ((fin + g - 1) / g) * g;
      if (count_q >= MAX_SECTIONS || fin > 64'(total_q)) begin
        batch.push_back(make_result(ST_ADD_FAIL, 8'd0, 32'd0, 17'd0));
      end else begin
        addr_q[count_q] = base_q + offset_q;
        size_q[count_q] = sz;
        armed_q[count_q] = 1'b0;
        countdown_q[count_q] = 32'd0;
        count_q++;
        offset_q = fin[31:0];
        batch.push_back(make_result(ST_ADDED, 8'(count_q), addr_q[count_q-1],
                                    17'(sz) + HDR_BYTES));
      end
    end else if (act == ACT_SAVE) begin
      if (id == 0 || id > count_q) begin
        batch.push_back(make_result(ST_SAVE_FAIL, 8'd0, 32'd0, 17'd0));
      end else if (dly == 0) begin
        batch.push_back(make_result(ST_WRITE, id, addr_q[id-1],
                                    17'(size_q[id-1]) + HDR_BYTES));
      end else begin
        armed_q[id-1] = 1'b1;
        if (countdown_q[id-1] < dly) countdown_q[id-1] = dly;
        batch.push_back(make_result(ST_ARMED, id, addr_q[id-1],
                                    17'(size_q[id-1]) + HDR_BYTES));
      end
    end else if (act == ACT_TICK && !paused_q) begin
      for (int i = 0; i < count_q; i++) begin
        if (armed_q[i] && countdown_q[i] != 0) begin
          countdown_q[i]--;
          if (countdown_q[i] == 0) begin
            armed_q[i] = 1'b0;
            batch.push_back(make_result(ST_WRITE, 8'(i + 1), addr_q[i],
                                        17'(size_q[i]) + HDR_BYTES));
          end
        end
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) result_queue.push_back(batch[k]);
  endtask

  always @(posedge clk) begin
    save_result_t got, want;
    if (rst) begin
      base_q <= 32'd0;
      total_q <= 32'd0;
      grain_q <= 8'd1;
      paused_q <= 1'b0;
      count_q = 0;
      offset_q = 32'd0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        armed_q[i] = 1'b0;
        countdown_q[i] = 32'd0;
      end
      result_queue.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE:  base_q <= cfg_data;
          REG_TOTAL: total_q <= cfg_data;
          REG_GRAIN: grain_q <= cfg_data[7:0];
          REG_PAUSE: paused_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[42:11],
               m_axis_tdata[59:43], m_axis_tlast};
        if (result_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = result_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p, got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= result_queue.size();
  end
endmodule

@@ tb/sv/testbench.sv @@
// Top of the testbench: stimulus, register writes and the verdict.
`timescale 1ns / 1ps
module testbench;
  import dsss_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          mismatches;
  int          pending;
  int          hold_cycles = 0;
  logic        long_hold = 1'b0;
  logic        fast_drain = 1'b0;
  int unsigned sections_known = 0;

  deferred_section_save_scheduler i_dut (.*);

  save_scheduler_checker i_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: long hold-offs on request, otherwise a random stall pattern unless fast_drain is set.
  always @(posedge clk) begin
    if (long_hold) begin
      hold_cycles <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= fast_drain || ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    // The expected count is registered from the checker's queue.
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A quiet tick may still be rotating the ring.
    repeat (300) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] act, logic [7:0] id, logic [15:0] sz,
                           logic [31:0] dly);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, dly, sz, id, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (act == ACT_ADD && sections_known < 16) sections_known++;
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned k;
    logic [31:0] dly;
    k = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: dly = 32'd0;
      1: dly = $urandom_range(1, 4);
      2: dly = $urandom_range(1, 30);
      default: dly = $urandom;
    endcase
    if (k < 12) begin
      send_item(ACT_ADD, 8'($urandom), 16'($urandom_range(0, 200)), $urandom);
    end else if (k < 14) begin
      send_item(ACT_ADD, 8'($urandom), 16'($urandom), $urandom);
    end else if (k < 50) begin
      send_item(ACT_SAVE, 8'($urandom_range(1, sections_known + 1)), 16'($urandom), dly);
    end else if (k < 53) begin
      send_item(ACT_SAVE, 8'($urandom), 16'($urandom), $urandom);
    end else if (k < 97) begin
      send_item(ACT_TICK, 8'($urandom), 16'($urandom), $urandom);
    end else begin
      send_item(2'd3, 8'($urandom), 16'($urandom), $urandom);
    end
  endtask

  task automatic random_phase(int n);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 10)) begin
        if (left > 0) begin
          random_item();
          left--;
        end
      end
      idle_sender();
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: default registers reject any add.
    send_item(ACT_ADD, 8'd0, 16'd0, 32'd0);
    send_item(ACT_SAVE, 8'd0, 16'd0, 32'd0);
    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0);
    send_item(2'd3, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_BASE, 32'hFFFF_FFF0);
    write_reg(REG_TOTAL, 32'hFFFF_FFFF);
    write_reg(REG_GRAIN, 32'd0);
    write_reg(REG_PAUSE, 32'd0);
    send_item(ACT_ADD, 8'd0, 16'd0, 32'd0);
    send_item(ACT_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_SAVE, 8'd1, 16'd0, 32'd0);
    send_item(ACT_SAVE, 8'd2, 16'd0, 32'd1);
    send_item(ACT_SAVE, 8'd1, 16'd0, 32'd2);
    send_item(ACT_SAVE, 8'd1, 16'd0, 32'd1);
    send_item(ACT_SAVE, 8'd3, 16'd0, 32'd1);
    send_item(ACT_SAVE, 8'hFF, 16'd0, 32'd0);
    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0);
    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0);
    send_item(ACT_SAVE, 8'd2, 16'd0, 32'hFFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_PAUSE, 32'd1);
    send_item(ACT_TICK, 8'd0, 16'd0, 32'd0);
    repeat (14) send_item(ACT_ADD, 8'd0, 16'd10, 32'd0);
    send_item(ACT_ADD, 8'd0, 16'd10, 32'd0);
    s_axis_tvalid <= 1'b0;
    drain_results();
    // The table is full now, so random adds fail while saves and ticks work.
    write_reg(REG_PAUSE, 32'd0);
    write_reg(REG_GRAIN, 32'd255);
    random_phase(30);
    write_reg(REG_GRAIN, 32'd7);
    write_reg(REG_BASE, 32'd0);
    write_reg(REG_TOTAL, 32'd0);
    // Long receiver hold-off while the sender keeps offering transactions.
    long_hold <= 1'b1;
    @(posedge clk);
    long_hold <= 1'b0;
    for (int k = 1; k <= 8; k++) send_item(ACT_SAVE, 8'(k), 16'd0, 32'(k));
    repeat (6) send_item(ACT_TICK, 8'd0, 16'd0, 32'd0);
    s_axis_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_PAUSE, 32'd1);
    random_phase(15);
    write_reg(REG_PAUSE, 32'd0);
    write_reg(REG_GRAIN, 32'd64);
    random_phase(30);
    fast_drain <= 1'b1;
    s_axis_tvalid <= 1'b0;
    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
